### hdl/crc8_frame_receive_checker_defines.svh
// Assertion macros shared by the frame checker RTL.
`ifndef CRC8_FRAME_RECEIVE_CHECKER_DEFINES_SVH
`define CRC8_FRAME_RECEIVE_CHECKER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CRC8FRC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("crc8frc: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CRC8FRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("crc8frc: next-cycle check failed");

`endif

### hdl/crc8frc_pkg.sv
package crc8frc_pkg;

	// Register indexes of the configuration port
	localparam logic [0:0] REG_NODE_ADDRESS = 1'b0;
	localparam logic [0:0] REG_CRC_POLY     = 1'b1;

	localparam logic [7:0] NODE_ADDRESS_RST = 8'h00;
	localparam logic [7:0] CRC_POLY_RST     = 8'h07;
	localparam logic [7:0] CRC_TOP_BIT      = 8'h80;

	typedef enum logic [2:0] {
		ST_ACCEPTED = 3'd0,
		ST_ADDRESS  = 3'd1,
		ST_CRC      = 3'd2,
		ST_SHORT    = 3'd3,
		ST_LONG     = 3'd4
	} status_t;

	// Per-frame context kept in the context memory
	typedef struct packed {
		logic [7:0] crc;
		logic [7:0] idx;
		logic [7:0] clen;
		logic       match;
		logic [7:0] held;
	} ctx_t;

	// One result item
	typedef struct packed {
		logic [7:0] data_byte;
		logic       data_valid;
		logic       frame_done;
		status_t    status;
		logic [7:0] flen;
	} res_t;

	// MSB-first CRC-8 over one byte, zero-free of reflection and final xor
	function automatic logic [7:0] crc8_byte(input logic [7:0] rem, input logic [7:0] b,
		input logic [7:0] poly);
		logic [7:0] r;
		r = rem ^ b;
		for (int k = 0; k < 8; k++) begin
			if ((r & CRC_TOP_BIT) != 8'h00) begin
				r = {r[6:0], 1'b0} ^ poly;
			end else begin
				r = {r[6:0], 1'b0};
			end
		end
		return r;
	endfunction

endpackage

### hdl/crc8frc_ctx_mem.sv
module crc8frc_ctx_mem (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  crc8frc_pkg::ctx_t wr_data,
	input  logic              rd_en,
	output crc8frc_pkg::ctx_t rd_data
);
	import crc8frc_pkg::*;

	ctx_t mem [1];
	ctx_t rd_raw_q;
	logic written_q;
	logic rd_ok_q;

	// Write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[0] <= wr_data;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_raw_q <= mem[0];
		end
	end

	// Track whether the entry holds a written context; unwritten reads as reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= 1'b0;
			rd_ok_q   <= 1'b0;
		end else begin
			if (wr_en) begin
				written_q <= 1'b1;
			end
			if (rd_en) begin
				rd_ok_q <= written_q;
			end
		end
	end

	assign rd_data = rd_ok_q ? rd_raw_q : '0;

endmodule

### hdl/crc8frc_step.sv
module crc8frc_step #(
	parameter int MAX_FRAME_BYTES = 255
) (
	input  crc8frc_pkg::ctx_t ctx_cur,
	input  logic [7:0]        rx_byte,
	input  logic              last_byte,
	input  logic [7:0]        node_address,
	input  logic [7:0]        crc_polynomial,
	output crc8frc_pkg::ctx_t ctx_next,
	output crc8frc_pkg::res_t res
);
	import crc8frc_pkg::*;

	localparam logic [7:0] MaxB  = 8'(MAX_FRAME_BYTES);
	localparam logic [8:0] MaxW  = 9'(MAX_FRAME_BYTES);

	logic       match;
	logic [7:0] clen;
	logic [8:0] limit;
	logic       crc_on;
	logic [7:0] crc;
	logic [8:0] count;
	logic [8:0] capped;
	logic       below_max;
	ctx_t       upd;
	status_t    status;

	// Capture address and claimed length, advance the CRC over the covered bytes
	always_comb begin
		match     = (ctx_cur.idx == 8'd0) ? (rx_byte == node_address) : ctx_cur.match;
		clen      = (ctx_cur.idx == 8'd2) ? rx_byte : ctx_cur.clen;
		limit     = {1'b0, clen} + 9'd4;
		crc_on    = (ctx_cur.idx < 8'd3) || ({1'b0, ctx_cur.idx} < limit);
		crc       = crc_on ? crc8_byte(ctx_cur.crc, rx_byte, crc_polynomial) : ctx_cur.crc;
		below_max = ctx_cur.idx < MaxB;
		count     = {1'b0, ctx_cur.idx} + 9'd1;
		capped    = (count > MaxW) ? MaxW : count;

		upd.crc   = crc;
		upd.idx   = below_max ? count[7:0] : MaxB;
		upd.clen  = clen;
		upd.match = match;
		upd.held  = rx_byte;
	end

	// Verdict: too long, then address, then short, then crc
	always_comb begin
		if (!below_max) begin
			status = ST_LONG;
		end else if (!match) begin
			status = ST_ADDRESS;
		end else if (count < limit) begin
			status = ST_SHORT;
		end else if (crc != 8'h00) begin
			status = ST_CRC;
		end else begin
			status = ST_ACCEPTED;
		end
	end

	// Build the result and drop the context at frame end
	always_comb begin
		res.data_byte  = ctx_cur.held;
		res.data_valid = (ctx_cur.idx >= 8'd2) && below_max;
		res.frame_done = last_byte;
		res.status     = last_byte ? status : ST_ACCEPTED;
		res.flen       = (last_byte && capped >= 9'd2) ? 8'(capped - 9'd2) : 8'd0;
		ctx_next       = last_byte ? '0 : upd;
	end

endmodule

### hdl/crc8_frame_receive_checker.sv
// Byte-stream frame checker: takes one byte per cycle unless stalled and returns
// one result per byte via one compute stage, then the output register. The frame
// context (CRC remainder, byte count, claimed length, address match, previous
// byte) lives in a one-entry synchronous memory with a registered read;
// back-to-back bytes take the compute stage's write-back through a forwarding
// register, so the input keeps that rate. No clearing pass runs after reset; the
// entry reads as zero until first written. node_address and crc_polynomial are
// to be written by the user only while no frame byte is in flight; the block
// does not enforce it. Results carry the previous byte (tentative when
// data_valid) and, on the last byte, the verdict and the forwarded length.
module crc8_frame_receive_checker #(
	parameter int MAX_FRAME_BYTES = 255
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] rx_byte,
	input  logic       last_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] data_byte,
	output logic       data_valid,
	output logic       frame_done,
	output logic [2:0] frame_status,
	output logic [7:0] forward_length,
	input  logic       cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [7:0] cfg_wdata
);
	import crc8frc_pkg::*;

	`include "crc8_frame_receive_checker_defines.svh"

	localparam logic [7:0] MaxB = 8'(MAX_FRAME_BYTES);

	logic [7:0] node_address_q;
	logic [7:0] crc_poly_q;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;
	logic       fwd_sel_s1;
	ctx_t       fwd_ctx_s1;
	logic       s1_adv;
	logic       in_xfer;

	ctx_t       rd_data;
	ctx_t       ctx_cur;
	ctx_t       ctx_next;
	res_t       res;
	res_t       out_q;
	logic       out_valid_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_address_q <= NODE_ADDRESS_RST;
			crc_poly_q     <= CRC_POLY_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NODE_ADDRESS: node_address_q <= cfg_wdata;
				REG_CRC_POLY:     crc_poly_q     <= cfg_wdata;
				default:          ;
			endcase
		end
	end

	// Handshake: stage 1 moves on when the output register is free or drains
	assign s1_adv   = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || s1_adv;
	assign in_xfer  = in_valid && in_ready;

	crc8frc_ctx_mem u_ctx_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (s1_adv),
		.wr_data (ctx_next),
		.rd_en   (in_xfer),
		.rd_data (rd_data)
	);

	// Stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1   <= 1'b0;
			fwd_sel_s1 <= 1'b0;
		end else if (in_xfer) begin
			valid_s1   <= 1'b1;
			fwd_sel_s1 <= s1_adv;
		end else if (s1_adv) begin
			valid_s1   <= 1'b0;
		end
	end

	// Stage 1 payload; hold the write-back that the memory read misses
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			byte_s1    <= rx_byte;
			last_s1    <= last_byte;
			fwd_ctx_s1 <= ctx_next;
		end
	end

	assign ctx_cur = fwd_sel_s1 ? fwd_ctx_s1 : rd_data;

	crc8frc_step #(
		.MAX_FRAME_BYTES (MAX_FRAME_BYTES)
	) u_step (
		.ctx_cur        (ctx_cur),
		.rx_byte        (byte_s1),
		.last_byte      (last_s1),
		.node_address   (node_address_q),
		.crc_polynomial (crc_poly_q),
		.ctx_next       (ctx_next),
		.res            (res)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign data_byte      = out_q.data_byte;
	assign data_valid     = out_q.data_valid;
	assign frame_done     = out_q.frame_done;
	assign frame_status   = out_q.status;
	assign forward_length = out_q.flen;

	`CRC8FRC_ASSERT_IMP(a_flen_bound, clk, arst_n, out_valid && frame_done, forward_length <= (MaxB - 8'd2))
	`CRC8FRC_ASSERT_IMP(a_idle_verdict, clk, arst_n, out_valid && !frame_done, (frame_status == ST_ACCEPTED) && (forward_length == 8'd0))
	`CRC8FRC_ASSERT_NEXT(a_fwd_on_overlap, clk, arst_n, in_xfer && s1_adv, fwd_sel_s1 && valid_s1)

endmodule

### tb/crc8_frame_monitor.sv
`timescale 1ns / 100ps

module crc8_frame_monitor #(
	parameter int MAX_FRAME_BYTES = 255
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [7:0] rx_byte,
	input  logic       last_byte,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic [7:0] data_byte,
	input  logic       data_valid,
	input  logic       frame_done,
	input  logic [2:0] frame_status,
	input  logic [7:0] forward_length,
	input  logic       cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [7:0] cfg_wdata,
	output int         mismatch_count,
	output int         results_due
);
	import crc8frc_pkg::*;

	// Register copies
	logic [7:0] node_addr;
	logic [7:0] poly;

	// Per-frame state
	logic [7:0] remainder;
	int         frame_pos;
	logic [7:0] claimed_len;
	logic       addr_ok;
	logic [7:0] prev_byte;

	// Results owed by the block, oldest first
	res_t byte_results[$];

	function automatic logic [7:0] crc_step(input logic [7:0] rem, input logic [7:0] b);
		logic [7:0] r;
		r = rem ^ b;
		repeat (8) begin
			r = r[7] ? ({r[6:0], 1'b0} ^ poly) : {r[6:0], 1'b0};
		end
		return r;
	endfunction

	function automatic void restart_frame();
		remainder = 8'h00;
		frame_pos = 0;
		claimed_len = 8'h00;
		addr_ok = 1'b0;
		prev_byte = 8'h00;
	endfunction

	// Advance the frame by one byte and return the result it causes
	function automatic res_t advance_frame(input logic [7:0] b, input logic lst);
		res_t r;
		int   pos;
		int   span;
		int   count;
		pos = frame_pos;
		r.data_byte = prev_byte;
		r.data_valid = (pos >= 2) && (pos + 1 <= MAX_FRAME_BYTES);
		r.frame_done = lst;
		r.status = ST_ACCEPTED;
		r.flen = 8'h00;
		if (pos == 0) begin
			addr_ok = (b == node_addr);
		end
		if (pos == 2) begin
			claimed_len = b;
		end
		span = int'(claimed_len) + 4;
		// bytes past address, command, length, payload and CRC skip the CRC
		if (pos < 3 || pos < span) begin
			remainder = crc_step(remainder, b);
		end
		prev_byte = b;
		frame_pos = (pos < MAX_FRAME_BYTES) ? pos + 1 : MAX_FRAME_BYTES;
		if (lst) begin
			count = (pos + 1 > MAX_FRAME_BYTES) ? MAX_FRAME_BYTES : pos + 1;
			// verdict priority: too long, address, short, CRC
			if (pos >= MAX_FRAME_BYTES) begin
				r.status = ST_LONG;
			end else if (!addr_ok) begin
				r.status = ST_ADDRESS;
			end else if (pos + 1 < span) begin
				r.status = ST_SHORT;
			end else if (remainder != 8'h00) begin
				r.status = ST_CRC;
			end
			r.flen = (count >= 2) ? 8'(count - 2) : 8'h00;
			restart_frame();
		end
		return r;
	endfunction

	task automatic check_field(input string field, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", field, want, got);
			mismatch_count++;
		end
	endtask

	// Track registers, predict on each input transfer, compare each output transfer
	always @(posedge clk or negedge arst_n) begin : watch
		res_t owed;
		if (!arst_n) begin
			node_addr = NODE_ADDRESS_RST;
			poly = CRC_POLY_RST;
			restart_frame();
			byte_results.delete();
			mismatch_count = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_NODE_ADDRESS: node_addr = cfg_wdata;
					REG_CRC_POLY:     poly = cfg_wdata;
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				byte_results.push_back(advance_frame(rx_byte, last_byte));
			end
			if (out_valid && out_ready) begin
				if (byte_results.size() == 0) begin
					$error("result with none owed: data_byte %0h, frame_done %0b",
						data_byte, frame_done);
					mismatch_count++;
				end else begin
					owed = byte_results.pop_front();
					check_field("data_byte", owed.data_byte, data_byte);
					check_field("data_valid", 8'(owed.data_valid), 8'(data_valid));
					check_field("frame_done", 8'(owed.frame_done), 8'(frame_done));
					check_field("frame_status", 8'(owed.status), 8'(frame_status));
					check_field("forward_length", owed.flen, forward_length);
				end
			end
		end
		results_due = byte_results.size();
	end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import crc8frc_pkg::*;

	localparam int MAX_BYTES = 255;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PHASE_BYTES = 150;
	localparam int HOLD_OFF_CYCLES = 200;

	typedef enum int {
		FK_GOOD,
		FK_PADDED,
		FK_BAD_CRC,
		FK_BAD_ADDR,
		FK_SHORT,
		FK_TINY,
		FK_NOISE,
		FK_BIG,
		FK_MAX,
		FK_OVERSIZE
	} frame_kind_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] rx_byte = 8'h00;
	logic       last_byte = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [7:0] data_byte;
	logic       data_valid;
	logic       frame_done;
	logic [2:0] frame_status;
	logic [7:0] forward_length;
	logic       cfg_we = 1'b0;
	logic [0:0] cfg_index = REG_NODE_ADDRESS;
	logic [7:0] cfg_wdata = 8'h00;

	int         mismatch_count;
	int         results_due;
	int         cycle_count = 0;
	bit         idle_on = 1'b0;
	bit         hold_off_req = 1'b0;
	logic [7:0] frame_q[$];
	logic [7:0] cur_addr = NODE_ADDRESS_RST;
	logic [7:0] cur_poly = CRC_POLY_RST;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	crc8_frame_receive_checker #(
		.MAX_FRAME_BYTES(MAX_BYTES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.data_byte(data_byte),
		.data_valid(data_valid),
		.frame_done(frame_done),
		.frame_status(frame_status),
		.forward_length(forward_length),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	crc8_frame_monitor #(
		.MAX_FRAME_BYTES(MAX_BYTES)
	) frame_monitor (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.last_byte(last_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.data_byte(data_byte),
		.data_valid(data_valid),
		.frame_done(frame_done),
		.frame_status(frame_status),
		.forward_length(forward_length),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.mismatch_count(mismatch_count),
		.results_due(results_due)
	);

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("crc8_frame_receive_checker verification failed");
			$finish;
		end
	end

	// Result side: random stalls, plus one long hold-off on request
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(negedge clk);
				hold_off_req = 1'b0;
				out_ready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 11)) @(negedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// CRC of the bytes queued so far under the current polynomial
	function automatic logic [7:0] frame_crc();
		logic [7:0] r;
		r = 8'h00;
		foreach (frame_q[k]) begin
			r = r ^ frame_q[k];
			repeat (8) begin
				r = r[7] ? ({r[6:0], 1'b0} ^ cur_poly) : {r[6:0], 1'b0};
			end
		end
		return r;
	endfunction

	function automatic frame_kind_t pick_kind();
		int r;
		r = $urandom_range(0, 199);
		if (r < 90) return FK_GOOD;
		if (r < 110) return FK_PADDED;
		if (r < 130) return FK_BAD_CRC;
		if (r < 146) return FK_BAD_ADDR;
		if (r < 162) return FK_SHORT;
		if (r < 172) return FK_TINY;
		if (r < 192) return FK_NOISE;
		if (r < 198) return FK_BIG;
		return FK_OVERSIZE;
	endfunction

	// Fill frame_q with one frame of the given kind
	task automatic build_frame(input frame_kind_t kind);
		int         plen;
		int         keep;
		logic [7:0] addr;
		frame_q.delete();
		addr = (kind == FK_BAD_ADDR) ? cur_addr ^ 8'($urandom_range(1, 255)) : cur_addr;
		case (kind)
			FK_TINY: begin
				frame_q.push_back($urandom_range(0, 1) ? cur_addr : 8'($urandom));
				if ($urandom_range(0, 1)) begin
					frame_q.push_back(8'($urandom));
				end
			end
			FK_NOISE: begin
				repeat ($urandom_range(1, 20)) frame_q.push_back(8'($urandom));
			end
			FK_OVERSIZE: begin
				frame_q.push_back($urandom_range(0, 1) ? cur_addr : 8'($urandom));
				repeat ($urandom_range(MAX_BYTES, MAX_BYTES + 14)) begin
					frame_q.push_back(8'($urandom));
				end
			end
			default: begin
				case (kind)
					FK_BIG:   plen = $urandom_range(13, MAX_BYTES - 4);
					FK_MAX:   plen = MAX_BYTES - 4;
					FK_SHORT: plen = $urandom_range(1, 12);
					default:  plen = $urandom_range(0, 12);
				endcase
				frame_q.push_back(addr);
				frame_q.push_back(8'($urandom));
				frame_q.push_back(8'(plen));
				repeat (plen) frame_q.push_back(8'($urandom));
				frame_q.push_back(frame_crc());
				if (kind == FK_BAD_CRC) begin
					frame_q[frame_q.size() - 1] ^= 8'(1 << $urandom_range(0, 7));
				end
				if (kind == FK_PADDED) begin
					repeat ($urandom_range(1, 8)) frame_q.push_back(8'($urandom));
				end
				// cut the frame somewhere past the length byte
				if (kind == FK_SHORT) begin
					keep = $urandom_range(3, plen + 3);
					while (frame_q.size() > keep) frame_q.pop_back();
				end
			end
		endcase
	endtask

	// Offer one byte from a falling edge and return at the falling edge after its transfer
	task automatic send_byte(input logic [7:0] b, input logic lst);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= b;
		last_byte <= lst;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Stop offering until every owed result has come out, then let the pipeline settle
	task automatic drain_results();
		in_valid <= 1'b0;
		while (results_due != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// Send frame_q, optionally draining the block before byte drain_at
	task automatic send_frame(input int drain_at);
		for (int k = 0; k < frame_q.size(); k++) begin
			if (k == drain_at) begin
				drain_results();
			end
			send_byte(frame_q[k], k == frame_q.size() - 1);
		end
	endtask

	task automatic write_register(input logic [0:0] idx, input logic [7:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		int sent;
		int drain_at;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// Directed frames under the reset register values
		frame_q = '{8'h00, 8'hFF, 8'h00};
		frame_q.push_back(frame_crc());
		send_frame(-1);
		// single byte with the wrong address
		frame_q = '{8'hFF};
		send_frame(-1);
		// two bytes, no length yet
		frame_q = '{8'h00, 8'h00};
		send_frame(-1);
		// one corrupted CRC bit
		frame_q = '{8'h00, 8'h5A, 8'h01, 8'hFF};
		frame_q.push_back(frame_crc() ^ 8'h01);
		send_frame(-1);
		// ends before the claimed payload
		frame_q = '{8'h00, 8'h01, 8'h05, 8'hA5, 8'h3C};
		send_frame(-1);
		// trailing bytes after a good CRC
		frame_q = '{8'h00, 8'h7E, 8'h01, 8'h81};
		frame_q.push_back(frame_crc());
		frame_q.push_back(8'hFF);
		frame_q.push_back(8'h00);
		send_frame(-1);
		drain_results();

		// Random frames over several register settings
		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				0: begin cur_addr = 8'hFF; cur_poly = 8'h00; idle_on = 1'b1; end
				1: begin cur_addr = 8'h00; cur_poly = 8'hFF; idle_on = 1'b1; end
				2: begin cur_addr = 8'($urandom); cur_poly = 8'($urandom); idle_on = 1'b0; end
				3: begin cur_addr = 8'($urandom); cur_poly = 8'h07; idle_on = 1'b1; end
				4: begin cur_addr = 8'h80; cur_poly = 8'h31; idle_on = 1'b1; end
				default: begin
					cur_addr = 8'($urandom);
					cur_poly = 8'($urandom);
					idle_on = 1'b0;
				end
			endcase
			write_register(REG_NODE_ADDRESS, cur_addr);
			write_register(REG_CRC_POLY, cur_poly);
			if (phase == 0) begin
				// back up the block with a full-size frame while results are held off
				hold_off_req = 1'b1;
				build_frame(FK_MAX);
				send_frame(-1);
				build_frame(FK_OVERSIZE);
				send_frame(-1);
				build_frame(FK_GOOD);
				send_frame(2);
			end
			sent = 0;
			while (sent < PHASE_BYTES) begin
				build_frame(pick_kind());
				drain_at = ($urandom_range(0, 39) == 0) ? $urandom_range(0, frame_q.size() - 1) : -1;
				sent += frame_q.size();
				send_frame(drain_at);
			end
			drain_results();
		end

		repeat (8) @(negedge clk);
		if (mismatch_count == 0 && results_due == 0) begin
			$display("crc8_frame_receive_checker verification clean");
		end else begin
			$display("crc8_frame_receive_checker verification failed");
		end
		$finish;
	end

endmodule

### filelist.f
+incdir+hdl
hdl/crc8frc_pkg.sv
hdl/crc8frc_ctx_mem.sv
hdl/crc8frc_step.sv
hdl/crc8_frame_receive_checker.sv
tb/crc8_frame_monitor.sv
tb/tb_top.sv
